FILE: rtl/frame_signal_statistics_defines.svh
// Assertion macros shared by the frame statistics blocks
// Depends on a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef FRAME_SIGNAL_STATISTICS_DEFINES_SVH
`define FRAME_SIGNAL_STATISTICS_DEFINES_SVH
`ifndef SYNTHESIS
// checked at every edge outside reset
`define FSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");
// checked at every edge, reset included
`define FSS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: reset check failed");
`else
`define FSS_ASSERT(lbl, prop)
`define FSS_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: rtl/fss_pkg.sv
// Shared types and defaults for the frame statistics block
// No dependencies; used by fss_ctrl, fss_datapath and the top level
`timescale 1ns / 1ps

package fss_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MAX_FRAME_DEF    = 4096;

    // controller to datapath commands
    typedef struct packed {
        logic take;      // sample accepted this cycle
        logic close;     // accepted sample ends the frame
        logic div_load;  // start the power division
        logic div_step;  // one quotient bit
        logic out_load;  // move the finished result to the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic at_limit;  // next sample reaches the frame length limit
        logic div_done;  // all quotient bits produced
    } t_status;

endpackage

FILE: rtl/fss_ctrl.sv
// Controller for the frame statistics block: handshakes and division sequencing
// Depends on fss_pkg and frame_signal_statistics_defines.svh
`timescale 1ns / 1ps
`include "frame_signal_statistics_defines.svh"

module fss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_sample,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fss_pkg::t_status i_status,
    output fss_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_DIV,
        S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   closes;
    logic   out_free;
    logic   result_ready;

    // a closing item needs the divider free
    assign closes     = i_last_sample | i_status.at_limit;
    assign o_in_ready = !closes || (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign result_ready = ((r_state == S_DIV) && i_status.div_done) || (r_state == S_WAIT);

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.take     = i_in_valid && o_in_ready;
        o_cmd.close    = i_in_valid && o_in_ready && closes;
        o_cmd.div_load = (r_state == S_PRIME);
        o_cmd.div_step = (r_state == S_DIV) && !i_status.div_done;
        o_cmd.out_load = result_ready && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.close) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = out_free ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    `FSS_ASSERT(a_load_when_free, o_cmd.out_load |-> (!r_out_valid || i_out_ready))
    `FSS_ASSERT(a_close_primes, o_cmd.close |=> (r_state == S_PRIME))
    `FSS_ASSERT_RST(a_rst_no_result, !i_rst_n |=> !o_out_valid)

endmodule

FILE: rtl/fss_datapath.sv
// Datapath for the frame statistics block: running values, square pipeline,
// serial restoring divider for power and the output register; uses fss_pkg
`timescale 1ns / 1ps
`include "frame_signal_statistics_defines.svh"

module fss_datapath #(
    parameter int SAMPLE_WIDTH = fss_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_FRAME    = fss_pkg::MAX_FRAME_DEF,
    parameter int COUNT_W      = $clog2(MAX_FRAME + 1),
    parameter int ENERGY_W     = 2 * SAMPLE_WIDTH - 2 + COUNT_W,
    parameter int POWER_W      = 2 * SAMPLE_WIDTH - 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fss_pkg::t_cmd                  i_cmd,
    output fss_pkg::t_status               o_status,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic        [COUNT_W-1:0]      o_leading_zeros,
    output logic        [COUNT_W-1:0]      o_sample_count,
    output logic signed [SAMPLE_WIDTH-1:0] o_peak_max,
    output logic signed [SAMPLE_WIDTH-1:0] o_peak_min,
    output logic        [ENERGY_W-1:0]     o_energy,
    output logic        [POWER_W-1:0]      o_power
);

    localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
    localparam int STEP_W = $clog2(ENERGY_W + 1);

    // running frame state
    logic        [COUNT_W-1:0]      r_count;
    logic                           r_still;
    logic        [COUNT_W-1:0]      r_zero_run;
    logic signed [SAMPLE_WIDTH-1:0] r_max;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic        [ENERGY_W-1:0]     r_energy;
    logic        [SQ_W-1:0]         r_sq;
    logic                           r_sq_valid;

    // frame snapshot taken at close; energy is taken at division load
    logic        [COUNT_W-1:0]      r_snap_lead;
    logic        [COUNT_W-1:0]      r_snap_count;
    logic signed [SAMPLE_WIDTH-1:0] r_snap_max;
    logic signed [SAMPLE_WIDTH-1:0] r_snap_min;
    logic        [ENERGY_W-1:0]     r_snap_energy;

    // divider
    logic [COUNT_W-1:0]  r_rem;
    logic [ENERGY_W-1:0] r_quo;
    logic [STEP_W-1:0]   r_step;

    logic                           first;
    logic                           is_zero;
    logic signed [SAMPLE_WIDTH-1:0] n_max;
    logic signed [SAMPLE_WIDTH-1:0] n_min;
    logic        [COUNT_W-1:0]      n_zero_run;
    logic                           n_still;
    logic        [COUNT_W-1:0]      count_inc;
    logic signed [2*SAMPLE_WIDTH-1:0] sq_full;
    logic        [ENERGY_W-1:0]     sq_term;
    logic        [ENERGY_W-1:0]     energy_sum;
    logic        [COUNT_W:0]        rem_sh;
    logic        [COUNT_W:0]        rem_diff;
    logic                           rem_ge;

    // per-sample updates
    assign first      = (r_count == '0);
    assign is_zero    = (i_sample == '0);
    assign n_max      = (first || (i_sample > r_max)) ? i_sample : r_max;
    assign n_min      = (first || (i_sample < r_min)) ? i_sample : r_min;
    assign n_still    = r_still && is_zero;
    assign n_zero_run = n_still ? (r_zero_run + 1'b1) : r_zero_run;
    assign count_inc  = r_count + 1'b1;
    assign sq_full    = i_sample * i_sample;

    // square is registered before accumulation
    assign sq_term    = r_sq_valid ? {{(ENERGY_W - SQ_W){1'b0}}, r_sq} : '0;
    assign energy_sum = r_energy + sq_term;

    // one restoring division step
    assign rem_sh   = {r_rem, r_quo[ENERGY_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_snap_count});
    assign rem_diff = rem_sh - {1'b0, r_snap_count};

    assign o_status.at_limit = (r_count == COUNT_W'(MAX_FRAME - 1));
    assign o_status.div_done = (r_step == STEP_W'(ENERGY_W));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_still    <= 1'b1;
            r_zero_run <= '0;
            r_energy   <= '0;
            r_sq_valid <= 1'b0;
            r_step     <= STEP_W'(ENERGY_W);
        end else begin
            r_sq_valid <= i_cmd.take;
            if (i_cmd.take) begin
                if (i_cmd.close) begin
                    r_count    <= '0;
                    r_still    <= 1'b1;
                    r_zero_run <= '0;
                end else begin
                    r_count    <= count_inc;
                    r_still    <= n_still;
                    r_zero_run <= n_zero_run;
                end
            end
            if (i_cmd.div_load) begin
                r_energy <= '0;
            end else begin
                r_energy <= energy_sum;
            end
            if (i_cmd.div_load) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sq  <= sq_full[SQ_W-1:0];
            r_max <= n_max;
            r_min <= n_min;
        end
        if (i_cmd.close) begin
            r_snap_lead  <= n_zero_run;
            r_snap_count <= count_inc;
            r_snap_max   <= n_max;
            r_snap_min   <= n_min;
        end
        if (i_cmd.div_load) begin
            r_snap_energy <= energy_sum;
            r_quo         <= energy_sum;
            r_rem         <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[ENERGY_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_leading_zeros <= r_snap_lead;
            o_sample_count  <= r_snap_count;
            o_peak_max      <= r_snap_max;
            o_peak_min      <= r_snap_min;
            o_energy        <= r_snap_energy;
            o_power         <= r_quo[POWER_W-1:0];
        end
    end

    // checks
    `FSS_ASSERT(a_count_bound, r_count <= COUNT_W'(MAX_FRAME - 1))
    `FSS_ASSERT(a_step_bound, r_step <= STEP_W'(ENERGY_W))

endmodule

FILE: rtl/frame_signal_statistics.sv
// Frame statistics: leading zeros, count, peaks, energy and power per frame.
// Samples are taken one per cycle while o_in_ready is high; after a frame's last sample
// the result passes the divider load, the bit-serial divider and the output register.
// A closing sample waits while the previous frame's division or result is pending,
// so a frame cannot close before that division is through. Synchronous active-low
// reset clears the count, zero run and energy; no result is pending after it.
`timescale 1ns / 1ps

module frame_signal_statistics #(
    parameter int SAMPLE_WIDTH = fss_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_FRAME    = fss_pkg::MAX_FRAME_DEF,
    parameter int COUNT_W      = $clog2(MAX_FRAME + 1),
    parameter int ENERGY_W     = 2 * SAMPLE_WIDTH - 2 + COUNT_W,
    parameter int POWER_W      = 2 * SAMPLE_WIDTH - 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic        [COUNT_W-1:0]      o_leading_zeros,
    output logic        [COUNT_W-1:0]      o_sample_count,
    output logic signed [SAMPLE_WIDTH-1:0] o_peak_max,
    output logic signed [SAMPLE_WIDTH-1:0] o_peak_min,
    output logic        [ENERGY_W-1:0]     o_energy,
    output logic        [POWER_W-1:0]      o_power
);

    fss_pkg::t_cmd    cmd;
    fss_pkg::t_status status;

    // handshakes and sequencing
    fss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // statistics and division
    fss_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_FRAME    (MAX_FRAME),
        .COUNT_W      (COUNT_W),
        .ENERGY_W     (ENERGY_W),
        .POWER_W      (POWER_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_sample        (i_sample),
        .o_leading_zeros (o_leading_zeros),
        .o_sample_count  (o_sample_count),
        .o_peak_max      (o_peak_max),
        .o_peak_min      (o_peak_min),
        .o_energy        (o_energy),
        .o_power         (o_power)
    );

endmodule

FILE: bench/frame_signal_statistics_test.sv
// Self-checking bench for frame_signal_statistics: directed frames, then random frames
// under several valid/ready idling mixes. Depends on fss_pkg and the block's RTL only.
`timescale 1ns / 1ps

module frame_signal_statistics_test;

    localparam int SAMPLE_W     = fss_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAX_FRAME    = fss_pkg::MAX_FRAME_DEF;
    localparam int COUNT_W      = $clog2(MAX_FRAME + 1);
    localparam int ENERGY_W     = 2 * SAMPLE_W - 2 + COUNT_W;
    localparam int POWER_W      = 2 * SAMPLE_W - 1;
    localparam int DRAIN_CYCLES = ENERGY_W + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [COUNT_W-1:0]  leading_zeros;
        logic [COUNT_W-1:0]  sample_count;
        logic [SAMPLE_W-1:0] peak_max;
        logic [SAMPLE_W-1:0] peak_min;
        logic [ENERGY_W-1:0] energy;
        logic [POWER_W-1:0]  power;
    } frame_stats_t;

    localparam frame_stats_t NO_STATS = '0;

    typedef struct packed {
        sample_t      sample;
        logic         last;
        logic         typed;
        frame_stats_t want;
    } sample_item_t;

    typedef struct packed {
        sample_t      sample;
        logic         last;
        int unsigned  repeats;
        logic         typed;
        frame_stats_t want;
    } stim_row_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    sample_t             i_sample      = '0;
    logic                i_last_sample = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [COUNT_W-1:0]  o_leading_zeros;
    logic [COUNT_W-1:0]  o_sample_count;
    sample_t             o_peak_max;
    sample_t             o_peak_min;
    logic [ENERGY_W-1:0] o_energy;
    logic [POWER_W-1:0]  o_power;

    frame_signal_statistics dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_last_sample   (i_last_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_leading_zeros (o_leading_zeros),
        .o_sample_count  (o_sample_count),
        .o_peak_max      (o_peak_max),
        .o_peak_min      (o_peak_min),
        .o_energy        (o_energy),
        .o_power         (o_power)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench state
    stim_row_t    directed_rows[$];
    sample_item_t feed_q[$];
    frame_stats_t stats_due[$];
    sample_item_t on_offer       = '0;
    int unsigned  samples_queued = 0;
    int unsigned  samples_taken  = 0;
    int unsigned  frames_seen    = 0;
    int unsigned  typed_frames   = 0;
    int unsigned  held_offers    = 0;
    int unsigned  errors         = 0;
    int unsigned  cycles         = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_left      = 0;

    // running frame statistics of the predictor
    logic            lead_open    = 1'b1;
    int unsigned     zero_run_len = 0;
    int unsigned     frame_len    = 0;
    sample_t         frame_max    = '0;
    sample_t         frame_min    = '0;
    longint unsigned frame_energy = 0;

    // fold one sample into the frame; returns 1 with the stats when the frame closes
    function automatic logic fold_sample(input sample_t s, input logic last,
                                         output frame_stats_t stats);
        longint wide;
        wide  = s;
        stats = NO_STATS;
        if (frame_len == 0) begin
            frame_max = s;
            frame_min = s;
        end else begin
            if (s > frame_max) frame_max = s;
            if (s < frame_min) frame_min = s;
        end
        if (lead_open && s == 0) zero_run_len++;
        else lead_open = 1'b0;
        frame_energy += longint'(wide * wide);
        frame_len++;
        // an overlong frame closes on its own at the length limit
        if (!last && frame_len < MAX_FRAME) return 1'b0;
        stats.leading_zeros = COUNT_W'(zero_run_len);
        stats.sample_count  = COUNT_W'(frame_len);
        stats.peak_max      = frame_max;
        stats.peak_min      = frame_min;
        stats.energy        = ENERGY_W'(frame_energy);
        stats.power         = POWER_W'(frame_energy / frame_len);
        lead_open    = 1'b1;
        zero_run_len = 0;
        frame_len    = 0;
        frame_max    = '0;
        frame_min    = '0;
        frame_energy = 0;
        return 1'b1;
    endfunction

    function automatic frame_stats_t make_stats(input int unsigned lz, input int unsigned cnt,
                                                input sample_t mx, input sample_t mn,
                                                input longint unsigned en,
                                                input longint unsigned pw);
        frame_stats_t st;
        st.leading_zeros = COUNT_W'(lz);
        st.sample_count  = COUNT_W'(cnt);
        st.peak_max      = mx;
        st.peak_min      = mn;
        st.energy        = ENERGY_W'(en);
        st.power         = POWER_W'(pw);
        return st;
    endfunction

    task automatic add_row(input sample_t s, input logic last, input int unsigned reps,
                           input logic typed, input frame_stats_t want);
        stim_row_t row;
        row.sample  = s;
        row.last    = last;
        row.repeats = reps;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_MIN;
            3:       return sample_t'(int'($urandom_range(2)) - 1);
            4:       return sample_t'(int'($urandom_range(255)) - 128);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // whole frames of random content, some with leading zero runs, until quota is met
    task automatic queue_random_frames(input int unsigned quota, input logic short_frames);
        int unsigned  len;
        int unsigned  lead;
        int unsigned  pushed;
        sample_item_t it;
        pushed = 0;
        while (pushed < quota) begin
            if (short_frames) len = $urandom_range(3, 1);
            else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: len = $urandom_range(8, 1);
                    5, 6, 7, 8:    len = $urandom_range(64, 9);
                    default:       len = $urandom_range(200, 65);
                endcase
            end
            lead = ($urandom_range(3) == 0) ? $urandom_range(len, 0) : 0;
            for (int i = 0; i < len; i++) begin
                it        = '0;
                it.sample = (i < lead) ? sample_t'(0) : random_sample();
                it.last   = (i == len - 1);
                feed_q.push_back(it);
                samples_queued++;
            end
            pushed += len;
        end
    endtask

    task automatic wait_drained();
        while (samples_taken != samples_queued || stats_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // sample sender: predicts on acceptance, then offers the next item or idles
    always @(posedge i_clk) begin : sender
        sample_item_t next;
        frame_stats_t predicted;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                samples_taken++;
                if (fold_sample(i_sample, i_last_sample, predicted)) begin
                    stats_due.push_back(on_offer.typed ? on_offer.want : predicted);
                    if (on_offer.typed) typed_frames++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next          = feed_q.pop_front();
                    on_offer      = next;
                    i_in_valid    <= 1'b1;
                    i_sample      <= next.sample;
                    i_last_sample <= next.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: checks each accepted result, stalls at random or for a long hold
    always @(posedge i_clk) begin : receiver
        frame_stats_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                frames_seen++;
                if (stats_due.size() == 0) begin
                    $error("result arrived with no frame pending");
                    errors++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("leading_zeros", want.leading_zeros, o_leading_zeros);
                    check_field("sample_count", want.sample_count, o_sample_count);
                    check_field("peak_max", $signed(want.peak_max), o_peak_max);
                    check_field("peak_min", $signed(want.peak_min), o_peak_min);
                    check_field("energy", want.energy, o_energy);
                    check_field("power", want.power, o_power);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                if (i_in_valid && !o_in_ready) held_offers++;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : run
        sample_item_t it;

        // directed frames: extremes, one-sample frames, all-zero frames, mixed signs
        add_row(SAMPLE_MAX, 1'b1, 1, 1'b1,
                make_stats(0, 1, SAMPLE_MAX, SAMPLE_MAX, 1073676289, 1073676289));
        add_row(SAMPLE_MIN, 1'b1, 1, 1'b1,
                make_stats(0, 1, SAMPLE_MIN, SAMPLE_MIN, 1073741824, 1073741824));
        add_row('0, 1'b1, 1, 1'b1, make_stats(1, 1, 0, 0, 0, 0));
        add_row('0, 1'b0, 2, 1'b0, NO_STATS);
        add_row('0, 1'b1, 1, 1'b1, make_stats(3, 3, 0, 0, 0, 0));
        add_row('0, 1'b0, 2, 1'b0, NO_STATS);
        add_row(16'sd5, 1'b0, 1, 1'b0, NO_STATS);
        add_row(-16'sd3, 1'b0, 1, 1'b0, NO_STATS);
        add_row(16'sd1, 1'b1, 1, 1'b0, NO_STATS);
        add_row(-16'sd1, 1'b0, 1, 1'b0, NO_STATS);
        add_row(16'sd1, 1'b0, 1, 1'b0, NO_STATS);
        add_row(SAMPLE_MAX, 1'b0, 1, 1'b0, NO_STATS);
        add_row(SAMPLE_MIN, 1'b1, 1, 1'b0, NO_STATS);
        add_row('0, 1'b0, 1, 1'b0, NO_STATS);
        add_row(16'sh5555, 1'b0, 1, 1'b0, NO_STATS);
        add_row(16'shAAAA, 1'b1, 1, 1'b0, NO_STATS);
        add_row(16'sd7, 1'b1, 1, 1'b0, NO_STATS);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].repeats; k++) begin
                it        = '0;
                it.sample = directed_rows[r].sample;
                it.last   = directed_rows[r].last;
                it.typed  = directed_rows[r].typed;
                it.want   = directed_rows[r].want;
                feed_q.push_back(it);
                samples_queued++;
            end
        end
        wait_drained();

        // random frames under each idling mix
        send_idle_pct = 0;  recv_stall_pct = 0;  queue_random_frames(300, 1'b0);
        wait_drained();
        send_idle_pct = 65; recv_stall_pct = 0;  queue_random_frames(300, 1'b0);
        wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 65; queue_random_frames(300, 1'b0);
        wait_drained();
        send_idle_pct = 6;  recv_stall_pct = 6;  queue_random_frames(300, 1'b0);
        wait_drained();

        // long output hold with short frames so the block backs up into its input
        send_idle_pct = 0;  recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        queue_random_frames(150, 1'b1);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (stats_due.size() != 0) begin
            $error("%0d frame results never arrived", stats_due.size());
            errors++;
        end

        $display("covered %0d samples in %0d checked frames (%0d with fixed results),",
                 samples_taken, frames_seen, typed_frames);
        $display("four idling mixes and a %0d-cycle output hold that held off %0d offers",
                 HOLD_CYCLES, held_offers);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
